// ----- src/bsr_pkg.sv -----
// Shared types and constants of the byte stream reassembler.
package bsr_pkg;

    localparam int CAPACITY    = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int IDX_W       = 64;
    localparam int ROOM_W      = 7;
    localparam int PEND_W      = 7;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  stream_index;
        logic [7:0]        data_byte;
        logic              ends_stream;
        logic [ROOM_W-1:0] free_space;
    } t_req;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              last_of_run;
        logic              stream_closed;
        logic [PEND_W-1:0] pending_bytes;
    } t_res;

    typedef struct packed {
        logic              is_marker;
        logic              sets_end;
        logic [IDX_W-1:0]  end_value;
        logic [IDX_W-1:0]  stream_index;
        logic [7:0]        data_byte;
        logic [ROOM_W-1:0] room;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ----- src/bsr_front.sv -----
// Front end: classify an incoming request and prepare its end index and room.
module bsr_front #(
    parameter int CAPACITY = bsr_pkg::CAPACITY
) (
    input  bsr_pkg::t_req i_req,
    output bsr_pkg::t_cmd o_cmd
);

    localparam logic [bsr_pkg::ROOM_W-1:0] ROOM_MAX = bsr_pkg::ROOM_W'(CAPACITY);

    logic marker;

    assign marker = (i_req.command == bsr_pkg::CMD_END);

    always_comb begin
        o_cmd.is_marker    = marker;
        o_cmd.sets_end     = marker | i_req.ends_stream;
        // marker carries the end index itself, a last byte ends one past it
        o_cmd.end_value    = marker ? i_req.stream_index
                                    : i_req.stream_index + bsr_pkg::IDX_W'(1);
        o_cmd.stream_index = i_req.stream_index;
        o_cmd.data_byte    = i_req.data_byte;
        o_cmd.room         = (i_req.free_space > ROOM_MAX) ? ROOM_MAX : i_req.free_space;
    end

endmodule

// ----- src/bsr_queue.sv -----
// Short request queue between front end and back end.
module bsr_queue #(
    parameter int DEPTH = bsr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bsr_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output bsr_pkg::t_cmd    o_cmd,
    output bsr_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bsr_pkg::t_cmd    r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_FULL);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/bsr_back.sv -----
// Back end: window store, head run scan, close check and result emission.
module bsr_back #(
    parameter int CAPACITY = bsr_pkg::CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsr_pkg::t_cmd    i_cmd,
    input  bsr_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_strobe,
    output bsr_pkg::t_res    o_res
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = bsr_pkg::IDX_W;
    localparam int PEND_W = bsr_pkg::PEND_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);
    localparam logic [SLOT_W:0]   SLOT_SPAN = (SLOT_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CLOSE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]          r_state,     n_state;
    bsr_pkg::t_cmd       r_cmd,       n_cmd;
    logic [IDX_W-1:0]    r_pushed,    n_pushed;
    logic [IDX_W-1:0]    r_end_pos,   n_end_pos;
    logic                r_end_known, n_end_known;
    logic                r_closed,    n_closed;
    logic [PEND_W-1:0]   r_held,      n_held;
    logic [SLOT_W-1:0]   r_head,      n_head;
    logic [SLOT_W-1:0]   r_scan,      n_scan;
    logic [CNT_W-1:0]    r_cnt,       n_cnt;
    logic [CNT_W-1:0]    r_left,      n_left;
    logic [SLOT_W-1:0]   r_off,       n_off;
    logic [CAPACITY-1:0] r_valid,     n_valid;
    logic                r_out_act,   n_out_act;
    logic                r_out_vb,    n_out_vb;
    logic                r_out_last,  n_out_last;
    logic                r_out_closed, n_out_closed;
    logic [PEND_W-1:0]   r_out_held,  n_out_held;

    logic [7:0]          r_window [CAPACITY];
    logic [7:0]          r_rd_data;

    logic [IDX_W:0]      diff_ext;
    logic                in_win;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   wr_slot;
    logic                wr_en;
    logic                rd_en;

    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_strobe = r_out_act;

    always_comb begin
        o_res.out_byte      = r_out_vb ? r_rd_data : 8'd0;
        o_res.byte_valid    = r_out_vb;
        o_res.last_of_run   = r_out_last;
        o_res.stream_closed = r_out_closed;
        o_res.pending_bytes = r_out_held;
    end

    // window test: no borrow means at or past the head
    assign diff_ext = {1'b0, r_cmd.stream_index} - {1'b0, r_pushed};
    assign in_win   = !r_cmd.is_marker && !r_closed && (r_cmd.room != '0)
                      && !diff_ext[IDX_W]
                      && (diff_ext[IDX_W-1:0] < IDX_W'(r_cmd.room));

    assign slot_sum = {1'b0, r_head} + {1'b0, r_off};
    assign wr_slot  = (slot_sum >= SLOT_SPAN) ? SLOT_W'(slot_sum - SLOT_SPAN)
                                              : slot_sum[SLOT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_pushed     = r_pushed;
        n_end_pos    = r_end_pos;
        n_end_known  = r_end_known;
        n_closed     = r_closed;
        n_held       = r_held;
        n_head       = r_head;
        n_scan       = r_scan;
        n_cnt        = r_cnt;
        n_left       = r_left;
        n_off        = r_off;
        n_valid      = r_valid;
        n_out_act    = 1'b0;
        n_out_vb     = r_out_vb;
        n_out_last   = r_out_last;
        n_out_closed = r_out_closed;
        n_out_held   = r_out_held;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_cmd   = i_cmd;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_cmd.sets_end) begin
                    n_end_known = 1'b1;
                    n_end_pos   = r_cmd.end_value;
                end
                n_cnt   = '0;
                n_off   = diff_ext[SLOT_W-1:0];
                n_state = in_win ? S_STORE : S_CLOSE;
            end
            S_STORE: begin
                if (!r_valid[wr_slot]) begin
                    wr_en            = 1'b1;
                    n_valid[wr_slot] = 1'b1;
                    n_held           = r_held + PEND_W'(1);
                    n_scan           = r_head;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_CLOSE;
                end
            end
            S_SCAN: begin
                if ((r_cnt != CNT_MAX) && r_valid[r_scan]) begin
                    n_cnt    = r_cnt + CNT_W'(1);
                    n_scan   = (r_scan == SLOT_LAST) ? '0 : r_scan + SLOT_W'(1);
                    n_pushed = r_pushed + IDX_W'(1);
                    n_held   = r_held - PEND_W'(1);
                end else begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (!r_closed && r_end_known && (r_pushed == r_end_pos)) begin
                    n_closed = 1'b1;
                end
                n_left  = r_cnt;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_out_act    = 1'b1;
                n_out_closed = r_closed;
                n_out_held   = r_held;
                if (r_left == '0) begin
                    n_out_vb   = 1'b0;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    rd_en           = 1'b1;
                    n_valid[r_head] = 1'b0;
                    n_head          = (r_head == SLOT_LAST) ? '0 : r_head + SLOT_W'(1);
                    n_left          = r_left - CNT_W'(1);
                    n_out_vb        = 1'b1;
                    n_out_last      = (r_left == CNT_W'(1));
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_window[wr_slot] <= r_cmd.data_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_window[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_scan       <= n_scan;
        r_left       <= n_left;
        r_off        <= n_off;
        r_out_vb     <= n_out_vb;
        r_out_last   <= n_out_last;
        r_out_closed <= n_out_closed;
        r_out_held   <= n_out_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pushed    <= '0;
            r_end_pos   <= '0;
            r_end_known <= 1'b0;
            r_closed    <= 1'b0;
            r_held      <= '0;
            r_head      <= '0;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_out_act   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pushed    <= n_pushed;
            r_end_pos   <= n_end_pos;
            r_end_known <= n_end_known;
            r_closed    <= n_closed;
            r_held      <= n_held;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_valid     <= n_valid;
            r_out_act   <= n_out_act;
        end
    end

endmodule

// ----- src/byte_stream_reassembler_unit.sv -----
// Top level of the byte stream reassembler: front end, request queue, back end.
//
// Usage: raise i_start with a request on i_req; the request is taken on a rising
// edge where i_start is high and o_busy is low. Each request carries one stream
// byte tagged with its absolute index, or an end-of-stream marker. Results appear
// on o_res for exactly one cycle each, flagged by o_strobe; the receiver cannot
// stall them, so they must be captured as they come. One request yields one
// result per released in-order byte, or a single empty result if nothing drains;
// the last of them carries last_of_run.
// Flow: a request is first registered into the queue; the back end then pops
// and checks it. A marker or a byte outside the window goes straight to the
// close check, a byte whose slot is already held goes there from the store test,
// and a stored byte is written, then the head run is scanned over the valid marks
// one byte per cycle. A released run is read from the window store through its
// single registered read port, one byte per cycle. Results of one request come
// in consecutive cycles, after the close check, the emit state and its registers.
// o_busy is high while the two-entry request queue is full.
// Reset (synchronous, active low) empties the queue and clears the valid marks,
// the pushed count, the end index and the closed flag; the store needs no sweep.
module byte_stream_reassembler_unit #(
    parameter int CAPACITY    = bsr_pkg::CAPACITY,
    parameter int QUEUE_DEPTH = bsr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  bsr_pkg::t_req i_req,
    output logic          o_strobe,
    output bsr_pkg::t_res o_res
);

    bsr_pkg::t_cmd    front_cmd;
    bsr_pkg::t_cmd    queue_cmd;
    bsr_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    // take a request whenever the queue has room
    assign o_busy = q_stat.full;
    assign push   = i_start && !o_busy;

    // classify: clamp room, work out the end index
    bsr_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_req (i_req),
        .o_cmd (front_cmd)
    );

    // hold classified requests until the back end is free
    bsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    // store, drain the head run, close the stream, emit results
    bsr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (queue_cmd),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

`ifndef SYNTHESIS
    // an empty result always ends its request
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.byte_valid) |-> o_res.last_of_run)
        else $error("empty result without last_of_run");

    // an empty result carries a zero byte
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.byte_valid) |-> (o_res.out_byte == 8'd0))
        else $error("empty result with non-zero byte");

    // a released run leaves without gaps
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last_of_run) |=> o_strobe)
        else $error("gap inside a released run");

    // the store never reports more pending bytes than its capacity
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.pending_bytes <= bsr_pkg::PEND_W'(CAPACITY)))
        else $error("pending count beyond capacity");
`endif

endmodule
